[rtl/tcm_pkg.sv]
`timescale 1ns / 1ps

package tcm_pkg;

    // Coordinates and box registers are signed Q16.16 words.
    localparam int COORD_W = 32;
    localparam int PRIM_W = 24;
    localparam int NUM_AXES = 3;
    localparam int NUM_VERTS = 3;
    localparam int NUM_REGS = 6;
    localparam int CFG_IDX_W = 3;

    // Sum of three coordinates, and three times a box bound.
    localparam int SUM_W = COORD_W + 2;
    // Numerator and denominator of the cell division; both stay below 2^34.
    localparam int REM_W = COORD_W + 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic [COORD_W-1:0] BOX_MIN_RESET = 32'd0;
    localparam logic [COORD_W-1:0] BOX_MAX_RESET = 32'd65536;

    // Control that travels with a word along the divider chain.
    typedef struct packed {
        logic                valid;
        logic [NUM_AXES-1:0] sat;
        logic [PRIM_W-1:0]   prim;
    } cell_ctl_t;

endpackage

[rtl/tcm_front.sv]
`timescale 1ns / 1ps

module tcm_front
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  en,
    input  logic                                                  in_valid,
    input  logic [tcm_pkg::NUM_VERTS*tcm_pkg::NUM_AXES-1:0][tcm_pkg::COORD_W-1:0] vert,
    input  logic [tcm_pkg::PRIM_W-1:0]                            prim,
    input  logic [tcm_pkg::NUM_AXES-1:0][tcm_pkg::COORD_W-1:0]    box_min,
    input  logic [tcm_pkg::NUM_AXES-1:0][tcm_pkg::COORD_W-1:0]    box_max,
    output tcm_pkg::cell_ctl_t                                    ctl,
    output logic [tcm_pkg::NUM_AXES-1:0][tcm_pkg::REM_W-1:0]      rem,
    output logic [tcm_pkg::NUM_AXES-1:0][tcm_pkg::REM_W-1:0]      den
);

    localparam int SW = tcm_pkg::SUM_W;
    localparam int RW = tcm_pkg::REM_W;

    // Box terms follow the registers through a register of their own, which does not stall.
    logic [tcm_pkg::NUM_AXES-1:0][SW-1:0] lo3_reg;
    logic [tcm_pkg::NUM_AXES-1:0][RW-1:0] den_reg;
    logic [tcm_pkg::NUM_AXES-1:0][RW-1:0] den_next;
    logic [tcm_pkg::NUM_AXES-1:0]         empty_reg;
    logic [tcm_pkg::NUM_AXES-1:0]         empty_next;

    logic                                 valid1_reg;
    logic [tcm_pkg::PRIM_W-1:0]           prim1_reg;
    logic [tcm_pkg::NUM_AXES-1:0][SW-1:0] sum1_reg;

    tcm_pkg::cell_ctl_t                   ctl_reg;
    tcm_pkg::cell_ctl_t                   ctl_next;
    logic [tcm_pkg::NUM_AXES-1:0][RW-1:0] rem_reg;
    logic [tcm_pkg::NUM_AXES-1:0][RW-1:0] rem_next;

    always_comb
    begin
        logic [RW-1:0] span;
        for (int a = 0; a < tcm_pkg::NUM_AXES; a++)
        begin
            span = RW'($signed(box_max[a])) - RW'($signed(box_min[a]));
            empty_next[a] = $signed(box_max[a]) <= $signed(box_min[a]);
            // An empty axis gets the largest divisor so that its quotient stays zero.
            den_next[a] = empty_next[a] ? '1 : span + (span << 1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < tcm_pkg::NUM_AXES; a++)
        begin
            lo3_reg[a] <= SW'($signed(box_min[a])) + (SW'($signed(box_min[a])) << 1);
            den_reg[a] <= den_next[a];
            empty_reg[a] <= empty_next[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prim1_reg <= prim;
            for (int a = 0; a < tcm_pkg::NUM_AXES; a++)
            begin
                sum1_reg[a] <= SW'($signed(vert[a])) + SW'($signed(vert[3 + a]))
                               + SW'($signed(vert[6 + a]));
            end
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        logic signed [RW:0] num;
        logic               neg;
        logic               over;
        ctl_next.valid = valid1_reg;
        ctl_next.prim = prim1_reg;
        ctl_next.sat = '0;
        rem_next = '0;
        for (int a = 0; a < tcm_pkg::NUM_AXES; a++)
        begin
            num = $signed({sum1_reg[a][SW-1], sum1_reg[a]})
                  - $signed({lo3_reg[a][SW-1], lo3_reg[a]});
            neg = num[RW];
            over = !neg && (num[RW-1:0] >= den_reg[a]);
            // Below the box or an empty extent gives zero; at or past the top it saturates.
            ctl_next.sat[a] = over && !empty_reg[a];
            rem_next[a] = (neg || over || empty_reg[a]) ? '0 : num[RW-1:0];
        end
    end

    assign ctl = ctl_reg;
    assign rem = rem_reg;
    assign den = den_reg;

endmodule

[rtl/tcm_cell.sv]
`timescale 1ns / 1ps

module tcm_cell
#(
    parameter int BITS = 10
)
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              en,
    input  logic [tcm_pkg::NUM_AXES-1:0][tcm_pkg::REM_W-1:0]  den,
    input  tcm_pkg::cell_ctl_t                                in_ctl,
    input  logic [tcm_pkg::NUM_AXES-1:0][tcm_pkg::REM_W-1:0]  in_rem,
    input  logic [tcm_pkg::NUM_AXES-1:0][BITS-1:0]            in_quo,
    output tcm_pkg::cell_ctl_t                                out_ctl,
    output logic [tcm_pkg::NUM_AXES-1:0][tcm_pkg::REM_W-1:0]  out_rem,
    output logic [tcm_pkg::NUM_AXES-1:0][BITS-1:0]            out_quo
);

    localparam int RW = tcm_pkg::REM_W;

    tcm_pkg::cell_ctl_t                         ctl_reg;
    logic [tcm_pkg::NUM_AXES-1:0][RW-1:0]       rem_reg;
    logic [tcm_pkg::NUM_AXES-1:0][RW-1:0]       rem_next;
    logic [tcm_pkg::NUM_AXES-1:0][BITS-1:0]     quo_reg;
    logic [tcm_pkg::NUM_AXES-1:0][BITS-1:0]     quo_next;

    // One restoring step per axis: the remainder doubles and the divisor comes off
    // when it fits, which yields the next quotient bit.
    always_comb
    begin
        logic [RW:0] dbl;
        logic        fits;
        for (int a = 0; a < tcm_pkg::NUM_AXES; a++)
        begin
            dbl = {in_rem[a], 1'b0};
            fits = dbl >= {1'b0, den[a]};
            rem_next[a] = fits ? RW'(dbl - {1'b0, den[a]}) : dbl[RW-1:0];
            quo_next[a] = {in_quo[a][BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_rem = rem_reg;
    assign out_quo = quo_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> ((rem_reg[0] == '0 || rem_reg[0] < den[0])
                        && (rem_reg[1] == '0 || rem_reg[1] < den[1])
                        && (rem_reg[2] == '0 || rem_reg[2] < den[2])))
        else $error("division remainder not below divisor");

    a_sat_zero_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> ((!ctl_reg.sat[0] || rem_reg[0] == '0)
                        && (!ctl_reg.sat[1] || rem_reg[1] == '0)
                        && (!ctl_reg.sat[2] || rem_reg[2] == '0)))
        else $error("saturated axis carries a remainder");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(ctl_reg.valid))
        else $error("cell valid changed while stalled");

endmodule

[rtl/triangle_centroid_morton_code_top.sv]
`timescale 1ns / 1ps

// Triangle centroid Morton coder.
// s_tdata carries one triangle per word: nine signed Q16.16 coordinates
// (v0 x,y,z, v1 x,y,z, v2 x,y,z) and a 24-bit primitive number. m_tdata returns
// the 3*BITS_PER_AXIS-bit Morton code of the centroid within the box, x highest
// in each bit triple, and the primitive number. One result word per input word.
// The box is written through cfg_we/cfg_index/cfg_data (0..2 min x,y,z, 3..5
// max x,y,z); write it only while no word is in flight.
// The front registers the coordinate sums, then the numerators and range checks;
// one divider cell follows per quotient bit, and then the output register.
// Throughput is one word per cycle while the receiver does not stall, set by the
// chain of divider cells, each of which takes a new word every enabled cycle.
// Reset clears all valid flags and sets the box to [0, 1.0) on each axis.
// When the receiver stalls, the whole chain and the output register hold and
// s_tready drops; it rises again the cycle the output word is taken.
module triangle_centroid_morton_code_top
#(
    parameter int BITS_PER_AXIS = 10
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z, prim_index
    input  logic [311:0]                     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // morton_code, prim_index_out, zero fill
    output logic [((3*BITS_PER_AXIS+24+7)/8)*8-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcm_pkg::COORD_W-1:0]      cfg_data
);

    localparam int B = BITS_PER_AXIS;
    localparam int CODE_W = 3 * B;
    localparam int OUT_W = ((CODE_W + tcm_pkg::PRIM_W + 7) / 8) * 8;
    localparam int RW = tcm_pkg::REM_W;
    localparam int NA = tcm_pkg::NUM_AXES;

    logic [NA-1:0][tcm_pkg::COORD_W-1:0] box_min_reg;
    logic [NA-1:0][tcm_pkg::COORD_W-1:0] box_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= {NA{tcm_pkg::BOX_MIN_RESET}};
            box_max_reg <= {NA{tcm_pkg::BOX_MAX_RESET}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcm_pkg::REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                tcm_pkg::REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                tcm_pkg::REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                tcm_pkg::REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                tcm_pkg::REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                tcm_pkg::REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [tcm_pkg::PRIM_W-1:0] prim_reg;

    assign en = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    tcm_pkg::cell_ctl_t ctl_s [B+1];
    logic [NA-1:0][RW-1:0] rem_s [B+1];
    logic [NA-1:0][B-1:0] quo_s [B+1];
    logic [NA-1:0][RW-1:0] den;

    tcm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .vert     (s_tdata[9*tcm_pkg::COORD_W-1:0]),
        .prim     (s_tdata[9*tcm_pkg::COORD_W +: tcm_pkg::PRIM_W]),
        .box_min  (box_min_reg),
        .box_max  (box_max_reg),
        .ctl      (ctl_s[0]),
        .rem      (rem_s[0]),
        .den      (den)
    );

    assign quo_s[0] = '0;

    for (genvar k = 0; k < B; k++)
    begin : g_cell
        tcm_cell #(.BITS(B)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .den     (den),
            .in_ctl  (ctl_s[k]),
            .in_rem  (rem_s[k]),
            .in_quo  (quo_s[k]),
            .out_ctl (ctl_s[k+1]),
            .out_rem (rem_s[k+1]),
            .out_quo (quo_s[k+1])
        );
    end

    always_comb
    begin
        logic [NA-1:0][B-1:0] idx;
        for (int a = 0; a < NA; a++)
        begin
            idx[a] = quo_s[B][a] | {B{ctl_s[B].sat[a]}};
        end
        for (int i = 0; i < B; i++)
        begin
            code_next[3*i+2] = idx[0][i];
            code_next[3*i+1] = idx[1][i];
            code_next[3*i]   = idx[2][i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= ctl_s[B].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg <= code_next;
            prim_reg <= ctl_s[B].prim;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = OUT_W'({prim_reg, code_reg});

endmodule
